// ===== hdl/gbp_pkg.sv =====
// Shared constants, control types and the range-to-width function of the bit-field packer.
`timescale 1ns / 1ps
`default_nettype none

package gbp_pkg;

   localparam int BIN_BITS = 64;
   localparam int MAX_VARS = 64;

   localparam int RANGE_W = 63;
   localparam int WID_W   = 7;
   localparam int POS_W   = 6;
   localparam int IDX_W   = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int CNT_W   = $clog2(MAX_VARS + 1);

   typedef struct packed {
      logic load_acc;
      logic scan_issue;
      logic idx_clr;
      logic idx_inc;
      logic best_clr;
      logic place;
      logic out_load;
      logic set_clr;
   } cmd_type;

   typedef struct packed {
      logic remain_zero;
      logic idx_at_end;
   } status_type;

   // Bits needed for a range: the bit length of range - 1, zero for a zero range, a full
   // word for the all-ones range, and never more than one bin.
   function automatic logic [WID_W-1:0] range_width(input logic [RANGE_W-1:0] dec,
                                                    input logic is_zero,
                                                    input logic is_full);
      logic [63:0]      x;
      logic [5:0]       pos;
      logic [WID_W-1:0] n;
      x   = {1'b0, dec};
      pos = '0;
      if (x[63:32] != '0) begin
         pos[5] = 1'b1;
         x      = x >> 32;
      end
      if (x[31:16] != '0) begin
         pos[4] = 1'b1;
         x      = x >> 16;
      end
      if (x[15:8] != '0) begin
         pos[3] = 1'b1;
         x      = x >> 8;
      end
      if (x[7:4] != '0) begin
         pos[2] = 1'b1;
         x      = x >> 4;
      end
      if (x[3:2] != '0) begin
         pos[1] = 1'b1;
         x      = x >> 2;
      end
      if (x[1]) begin
         pos[0] = 1'b1;
      end
      if (is_full) begin
         n = WID_W'(64);
      end else if (is_zero || dec == '0) begin
         n = '0;
      end else begin
         n = WID_W'({1'b0, pos}) + WID_W'(1);
      end
      if (n > WID_W'(BIN_BITS)) begin
         n = WID_W'(BIN_BITS);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/gbp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module gbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/gbp_datapath.sv =====
// Datapath of the packer: width stage, stores, greedy scan unit and result register.
`timescale 1ns / 1ps
`default_nettype none

module gbp_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [gbp_pkg::RANGE_W-1:0]   req_range,
   input  wire gbp_pkg::cmd_type              cmd,
   output      gbp_pkg::status_type           status,
   output      logic [gbp_pkg::POS_W-1:0]     rsp_var_index,
   output      logic [gbp_pkg::POS_W-1:0]     rsp_word_index,
   output      logic [gbp_pkg::POS_W-1:0]     rsp_bit_offset,
   output      logic [gbp_pkg::WID_W-1:0]     rsp_field_width,
   output      logic                          rsp_final_res
);

   // Stage A: decremented range and its special cases.
   logic                          a_valid_ff, a_valid_in;
   logic [gbp_pkg::RANGE_W-1:0]   a_dec_ff;
   logic                          a_zero_ff;
   logic                          a_full_ff;

   logic [gbp_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [gbp_pkg::CNT_W-1:0]     remain_ff, remain_in;
   logic [gbp_pkg::MAX_VARS-1:0]  placed_ff, placed_in;
   logic [gbp_pkg::WID_W-1:0]     used_ff, used_in;
   logic [gbp_pkg::POS_W-1:0]     word_ff, word_in;
   logic [gbp_pkg::IDX_W-1:0]     idx_ff, idx_in;

   logic                          rd_valid_ff, rd_valid_in;
   logic [gbp_pkg::IDX_W-1:0]     rd_idx_ff;
   logic                          best_found_ff, best_found_in;
   logic [gbp_pkg::IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [gbp_pkg::WID_W-1:0]     best_w_ff, best_w_in;

   logic [gbp_pkg::POS_W-1:0]     out_var_ff;
   logic [gbp_pkg::POS_W-1:0]     out_word_ff;
   logic [gbp_pkg::POS_W-1:0]     out_off_ff;
   logic [gbp_pkg::WID_W-1:0]     out_w_ff;
   logic                          out_final_ff;

   logic [gbp_pkg::WID_W-1:0]     new_width;
   logic                          store_ok;
   logic [gbp_pkg::IDX_W-1:0]     load_addr;
   logic [gbp_pkg::WID_W-1:0]     free_bits;
   logic                          cand_ok;

   logic                          wid_we;
   logic [gbp_pkg::WID_W-1:0]     wid_rdata;
   logic                          pos_we;
   logic [gbp_pkg::IDX_W-1:0]     pos_waddr;
   logic [gbp_pkg::POS_W-1:0]     word_wdata;
   logic [gbp_pkg::POS_W-1:0]     off_wdata;
   logic [gbp_pkg::POS_W-1:0]     word_rdata;
   logic [gbp_pkg::POS_W-1:0]     off_rdata;

   assign new_width = gbp_pkg::range_width(a_dec_ff, a_zero_ff, a_full_ff);
   assign store_ok  = a_valid_ff && (count_ff < gbp_pkg::CNT_W'(gbp_pkg::MAX_VARS));
   assign load_addr = count_ff[gbp_pkg::IDX_W-1:0];
   assign free_bits = gbp_pkg::WID_W'(gbp_pkg::BIN_BITS) - used_ff;

   assign cand_ok = rd_valid_ff && !placed_ff[rd_idx_ff] &&
                    (wid_rdata <= free_bits) && (wid_rdata > best_w_ff);

   // Zero-width variables get their placement at load time; packing writes the rest.
   assign wid_we     = store_ok;
   assign pos_we     = (store_ok && new_width == '0) || (cmd.place && best_found_ff);
   assign pos_waddr  = cmd.place ? best_idx_ff : load_addr;
   assign word_wdata = cmd.place ? word_ff : '0;
   assign off_wdata  = cmd.place ? used_ff[gbp_pkg::POS_W-1:0] : '0;

   assign a_valid_in  = cmd.load_acc;
   assign rd_valid_in = cmd.scan_issue;

   always_comb begin
      count_in  = count_ff;
      remain_in = remain_ff;
      placed_in = placed_ff;
      used_in   = used_ff;
      word_in   = word_ff;
      if (store_ok) begin
         count_in = count_ff + gbp_pkg::CNT_W'(1);
         if (new_width == '0) begin
            placed_in[load_addr] = 1'b1;
         end else begin
            remain_in = remain_ff + gbp_pkg::CNT_W'(1);
         end
      end
      if (cmd.place) begin
         if (best_found_ff) begin
            placed_in[best_idx_ff] = 1'b1;
            used_in                = used_ff + best_w_ff;
            remain_in              = remain_ff - gbp_pkg::CNT_W'(1);
         end else begin
            word_in = word_ff + gbp_pkg::POS_W'(1);
            used_in = '0;
         end
      end
      if (cmd.set_clr) begin
         count_in  = '0;
         remain_in = '0;
         placed_in = '0;
         used_in   = '0;
         word_in   = '0;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + gbp_pkg::IDX_W'(1);
      end
   end

   always_comb begin
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_w_in     = best_w_ff;
      if (cmd.best_clr) begin
         best_found_in = 1'b0;
         best_w_in     = '0;
      end else if (cand_ok) begin
         best_found_in = 1'b1;
         best_idx_in   = rd_idx_ff;
         best_w_in     = wid_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         count_ff      <= '0;
         remain_ff     <= '0;
         placed_ff     <= '0;
         used_ff       <= '0;
         word_ff       <= '0;
         idx_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         best_found_ff <= 1'b0;
         best_w_ff     <= '0;
      end else begin
         a_valid_ff    <= a_valid_in;
         count_ff      <= count_in;
         remain_ff     <= remain_in;
         placed_ff     <= placed_in;
         used_ff       <= used_in;
         word_ff       <= word_in;
         idx_ff        <= idx_in;
         rd_valid_ff   <= rd_valid_in;
         best_found_ff <= best_found_in;
         best_w_ff     <= best_w_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_acc) begin
         a_dec_ff  <= req_range - gbp_pkg::RANGE_W'(1);
         a_zero_ff <= (req_range == '0);
         a_full_ff <= (req_range == '1);
      end
      rd_idx_ff   <= idx_ff;
      best_idx_ff <= best_idx_in;
      if (cmd.out_load) begin
         out_var_ff   <= gbp_pkg::POS_W'(idx_ff);
         out_word_ff  <= word_rdata;
         out_off_ff   <= off_rdata;
         out_w_ff     <= wid_rdata;
         out_final_ff <= status.idx_at_end;
      end
   end

   assign status.remain_zero = (remain_ff == '0);
   assign status.idx_at_end  = (gbp_pkg::CNT_W'(idx_ff) == count_ff - gbp_pkg::CNT_W'(1));

   gbp_ram #(.WIDTH(gbp_pkg::WID_W), .DEPTH(gbp_pkg::MAX_VARS)) u_width_ram (
      .clock   (clock),
      .wr_en   (wid_we),
      .wr_addr (load_addr),
      .wr_data (new_width),
      .rd_addr (idx_ff),
      .rd_data (wid_rdata)
   );

   gbp_ram #(.WIDTH(gbp_pkg::POS_W), .DEPTH(gbp_pkg::MAX_VARS)) u_word_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (word_wdata),
      .rd_addr (idx_ff),
      .rd_data (word_rdata)
   );

   gbp_ram #(.WIDTH(gbp_pkg::POS_W), .DEPTH(gbp_pkg::MAX_VARS)) u_offset_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (off_wdata),
      .rd_addr (idx_ff),
      .rd_data (off_rdata)
   );

   assign rsp_var_index   = out_var_ff;
   assign rsp_word_index  = out_word_ff;
   assign rsp_bit_offset  = out_off_ff;
   assign rsp_field_width = out_w_ff;
   assign rsp_final_res   = out_final_ff;

endmodule

`default_nettype wire

// ===== hdl/gbp_ctrl.sv =====
// Controller of the packer: load, greedy scan rounds and result delivery.
`timescale 1ns / 1ps
`default_nettype none

module gbp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_last,
   output      logic                 req_stall,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire gbp_pkg::status_type  status,
   output      gbp_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_LOAD,
      S_FLUSH,
      S_PREP,
      S_SCAN,
      S_TAIL,
      S_DECIDE,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_WAIT
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;
   logic      req_acc;
   logic      rsp_acc;

   assign req_acc = req_valid && !req_stall_ff;
   assign rsp_acc = rsp_valid_ff && !rsp_stall;

   always_comb begin
      cmd          = '0;
      cmd.load_acc = req_acc;
      unique case (state_ff)
         S_LOAD:      ;
         S_FLUSH:     ;
         S_PREP: begin
            cmd.idx_clr  = 1'b1;
            cmd.best_clr = 1'b1;
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            cmd.idx_inc    = !status.idx_at_end;
         end
         S_TAIL:      ;
         S_DECIDE:    cmd.place = 1'b1;
         S_EMIT_RD:   ;
         S_EMIT_LD:   cmd.out_load = 1'b1;
         S_EMIT_WAIT: begin
            cmd.idx_inc = rsp_acc && !status.idx_at_end;
            cmd.set_clr = rsp_acc && status.idx_at_end;
         end
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: begin
               if (req_acc && req_last) begin
                  state_ff     <= S_FLUSH;
                  req_stall_ff <= 1'b1;
               end
            end
            S_FLUSH: state_ff <= S_PREP;
            S_PREP: begin
               state_ff <= status.remain_zero ? S_EMIT_RD : S_SCAN;
            end
            S_SCAN: begin
               if (status.idx_at_end) begin
                  state_ff <= S_TAIL;
               end
            end
            S_TAIL:    state_ff <= S_DECIDE;
            S_DECIDE:  state_ff <= S_PREP;
            S_EMIT_RD: state_ff <= S_EMIT_LD;
            S_EMIT_LD: begin
               state_ff     <= S_EMIT_WAIT;
               rsp_valid_ff <= 1'b1;
            end
            S_EMIT_WAIT: begin
               if (rsp_acc) begin
                  rsp_valid_ff <= 1'b0;
                  if (status.idx_at_end) begin
                     state_ff     <= S_LOAD;
                     req_stall_ff <= 1'b0;
                  end else begin
                     state_ff <= S_EMIT_RD;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/greedy_bitfield_packer.sv =====
// Top level of the greedy bit-field packer.
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   req_range, req_last
//   rsp       out         rsp_valid/rsp_stall   rsp_var_index, rsp_word_index,
//                                               rsp_bit_offset, rsp_field_width,
//                                               rsp_final_res
//
// Ranges load at one item per cycle while req_stall is low, through the width stage.
// After the item with last set, packing runs one scan of the width store per
// placed variable and per closed word, each scan reading every stored width in
// turn through the single read port of the width store.
// Results then leave one at a time, the next read waiting until rsp_valid is taken.
// Reset is synchronous and returns the block to loading with no stored set.
`timescale 1ns / 1ps
`default_nettype none

module greedy_bitfield_packer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [gbp_pkg::RANGE_W-1:0]   req_range,
   input  wire logic                          req_last,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [gbp_pkg::POS_W-1:0]     rsp_var_index,
   output      logic [gbp_pkg::POS_W-1:0]     rsp_word_index,
   output      logic [gbp_pkg::POS_W-1:0]     rsp_bit_offset,
   output      logic [gbp_pkg::WID_W-1:0]     rsp_field_width,
   output      logic                          rsp_final_res
);

   gbp_pkg::cmd_type    cmd;
   gbp_pkg::status_type status;

   gbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gbp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_range       (req_range),
      .cmd             (cmd),
      .status          (status),
      .rsp_var_index   (rsp_var_index),
      .rsp_word_index  (rsp_word_index),
      .rsp_bit_offset  (rsp_bit_offset),
      .rsp_field_width (rsp_field_width),
      .rsp_final_res   (rsp_final_res)
   );

endmodule

`default_nettype wire

// ===== hdl/gbp_checker.sv =====
// Port-level checks for the bit-field packer and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gbp_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          req_last,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [gbp_pkg::POS_W-1:0]     rsp_var_index,
   input wire logic [gbp_pkg::POS_W-1:0]     rsp_bit_offset,
   input wire logic [gbp_pkg::WID_W-1:0]     rsp_field_width,
   input wire logic                          rsp_final_res
);

   // A stalled item stays on the result port unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_var_index) &&
      $stable(rsp_final_res))
      else $error("result item changed while stalled");

   // Once the last item of a set is taken, no further item is taken.
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall)
      else $error("input taken after the last item of a set");

   // Loading and delivery never overlap.
   a_no_load_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input ready while results are pending");

   // Every field fits inside one bin.
   a_field_in_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (8'(rsp_bit_offset) + 8'(rsp_field_width) <= 8'(gbp_pkg::BIN_BITS)))
      else $error("field crosses the end of its word");

   // After a final result is taken, rsp_valid drops; the next result starts a new set at index zero.
   a_index_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_final_res |=> !rsp_valid)
      else $error("result shown right after the final one");

endmodule

bind greedy_bitfield_packer gbp_checker u_gbp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_last        (req_last),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_var_index   (rsp_var_index),
   .rsp_bit_offset  (rsp_bit_offset),
   .rsp_field_width (rsp_field_width),
   .rsp_final_res   (rsp_final_res)
);

`default_nettype wire

// ===== tb/tb_greedy_bitfield_packer.sv =====
// Self-checking testbench for the greedy bit-field packer: directed corner sets, then random sets.
`timescale 1ns / 1ps

module tb_greedy_bitfield_packer;

   localparam int RUN_LIMIT    = 1_000_000;
   localparam int DRAIN_CYCLES = 400;
   localparam int RANDOM_ITEMS = 310;
   localparam int GAP_PERCENT  = 6;
   localparam int MAX_SHOWN    = 10;
   localparam logic [gbp_pkg::RANGE_W-1:0] WHOLE_WORD = '1;

   typedef struct packed {
      logic [gbp_pkg::POS_W-1:0] var_index;
      logic [gbp_pkg::POS_W-1:0] word_index;
      logic [gbp_pkg::POS_W-1:0] bit_offset;
      logic [gbp_pkg::WID_W-1:0] field_width;
      logic                      final_res;
   } placement_type;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic [gbp_pkg::RANGE_W-1:0] req_range = '0;
   logic                        req_last  = 1'b0;
   logic                        rsp_stall = 1'b0;
   wire logic                        req_stall;
   wire logic                        rsp_valid;
   wire logic [gbp_pkg::POS_W-1:0]   rsp_var_index;
   wire logic [gbp_pkg::POS_W-1:0]   rsp_word_index;
   wire logic [gbp_pkg::POS_W-1:0]   rsp_bit_offset;
   wire logic [gbp_pkg::WID_W-1:0]   rsp_field_width;
   wire logic                        rsp_final_res;

   // Placements still owed by the block, oldest first.
   placement_type             placements_due[$];
   // Widths of the set being loaded, as the block should hold them.
   logic [gbp_pkg::WID_W-1:0] held_width [gbp_pkg::MAX_VARS];
   int                        held_count  = 0;
   int                        fault_count = 0;
   int                        cycle_count = 0;
   int                        items_sent  = 0;
   bit                        calm        = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   greedy_bitfield_packer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_range       (req_range),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_var_index   (rsp_var_index),
      .rsp_word_index  (rsp_word_index),
      .rsp_bit_offset  (rsp_bit_offset),
      .rsp_field_width (rsp_field_width),
      .rsp_final_res   (rsp_final_res)
   );

   function automatic bit take_gap();
      return !calm && ($urandom_range(99) < GAP_PERCENT);
   endfunction

   function automatic void note_fault(input string what);
      if (fault_count < MAX_SHOWN) begin
         $display("%0t: %s", $realtime, what);
      end
      fault_count++;
   endfunction

   // Smallest n with 2^n >= range; the all-ones range takes a whole word.
   function automatic int bits_for_range(input logic [gbp_pkg::RANGE_W-1:0] r);
      int          n;
      logic [63:0] wide;
      wide = {1'b0, r};
      n    = 0;
      if (r == WHOLE_WORD) begin
         n = 64;
      end else begin
         while (n < 63 && (64'd1 << n) < wide) n++;
      end
      if (n > gbp_pkg::BIN_BITS) begin
         n = gbp_pkg::BIN_BITS;
      end
      return n;
   endfunction

   // Greedy packing of the held set: each word keeps taking the widest field
   // that still fits, lowest index on ties. Zero-width fields sit at word 0,
   // offset 0 and take no space.
   function automatic void pack_held_set();
      logic [gbp_pkg::POS_W-1:0]    word_of   [gbp_pkg::MAX_VARS];
      logic [gbp_pkg::POS_W-1:0]    offset_of [gbp_pkg::MAX_VARS];
      logic [gbp_pkg::MAX_VARS-1:0] placed;
      int                           unplaced;
      int                           word;
      int                           used;
      int                           best;
      int                           best_w;
      int                           w;
      placement_type                p;
      placed   = '0;
      unplaced = 0;
      word     = 0;
      for (int i = 0; i < held_count; i++) begin
         if (held_width[i] == '0) begin
            word_of[i]   = '0;
            offset_of[i] = '0;
            placed[i]    = 1'b1;
         end else begin
            unplaced++;
         end
      end
      while (unplaced > 0) begin
         used = 0;
         do begin
            best   = -1;
            best_w = 0;
            for (int i = 0; i < held_count; i++) begin
               w = int'(held_width[i]);
               if (!placed[i] && w <= gbp_pkg::BIN_BITS - used && w > best_w) begin
                  best   = i;
                  best_w = w;
               end
            end
            if (best >= 0) begin
               word_of[best]   = gbp_pkg::POS_W'(word);
               offset_of[best] = gbp_pkg::POS_W'(used);
               placed[best]    = 1'b1;
               used           += best_w;
               unplaced--;
            end
         end while (best >= 0);
         word++;
      end
      for (int k = 0; k < held_count; k++) begin
         p.var_index   = gbp_pkg::POS_W'(k);
         p.word_index  = word_of[k];
         p.bit_offset  = offset_of[k];
         p.field_width = held_width[k];
         p.final_res   = (k + 1 == held_count);
         placements_due = {placements_due, p};
      end
      held_count = 0;
   endfunction

   // Items beyond the store size are dropped, but a dropped last item still
   // closes the set.
   function automatic void note_accepted(input logic [gbp_pkg::RANGE_W-1:0] r,
                                         input logic l);
      if (held_count < gbp_pkg::MAX_VARS) begin
         held_width[held_count] = gbp_pkg::WID_W'(bits_for_range(r));
         held_count++;
      end
      if (l) begin
         pack_held_set();
      end
   endfunction

   // Range mix that covers every width, dense small fields and all 63 bits.
   function automatic logic [gbp_pkg::RANGE_W-1:0] random_range();
      logic [63:0] raw;
      int          len;
      raw = {$urandom, $urandom};
      len = 63;
      case ($urandom_range(9))
         0: return gbp_pkg::RANGE_W'($urandom_range(1));
         1: return WHOLE_WORD;
         2: return (gbp_pkg::RANGE_W'(1) << $urandom_range(62)) +
                   gbp_pkg::RANGE_W'($urandom_range(1));
         3, 4, 5: len = $urandom_range(1, 8);
         default: len = $urandom_range(1, 63);
      endcase
      return gbp_pkg::RANGE_W'(raw & ((64'd1 << len) - 64'd1));
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so back-to-back items need no lowering of valid.
   task automatic send_range(input logic [gbp_pkg::RANGE_W-1:0] r, input logic l);
      while (take_gap()) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_range = r;
      req_last  = l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      note_accepted(r, l);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic test_single_field();
      send_range(gbp_pkg::RANGE_W'(5), 1'b1);
   endtask

   task automatic test_range_extremes();
      logic [gbp_pkg::RANGE_W-1:0] corners [14] = '{
         gbp_pkg::RANGE_W'(0), gbp_pkg::RANGE_W'(1), gbp_pkg::RANGE_W'(2),
         gbp_pkg::RANGE_W'(3), gbp_pkg::RANGE_W'(4),
         WHOLE_WORD, WHOLE_WORD - gbp_pkg::RANGE_W'(1),
         gbp_pkg::RANGE_W'(64'h4000_0000_0000_0000),
         gbp_pkg::RANGE_W'(64'h4000_0000_0000_0001),
         gbp_pkg::RANGE_W'(64'h1_0000_0000), gbp_pkg::RANGE_W'(64'h1_0000_0001),
         gbp_pkg::RANGE_W'(255), gbp_pkg::RANGE_W'(256), gbp_pkg::RANGE_W'(257)};
      foreach (corners[i]) begin
         send_range(corners[i], i == 13);
      end
   endtask

   task automatic test_zero_width_fields();
      send_range(gbp_pkg::RANGE_W'(0), 1'b0);
      send_range(gbp_pkg::RANGE_W'(1), 1'b0);
      send_range(gbp_pkg::RANGE_W'(0), 1'b1);
   endtask

   task automatic test_whole_word_fields();
      send_range(WHOLE_WORD, 1'b0);
      send_range(WHOLE_WORD, 1'b1);
   endtask

   // A full store, then one dropped item and a dropped last item.
   task automatic test_oversized_set();
      for (int i = 0; i < gbp_pkg::MAX_VARS + 2; i++) begin
         send_range(random_range(), i == gbp_pkg::MAX_VARS + 1);
      end
   endtask

   task automatic test_random_sets();
      int start;
      int size;
      int pick;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         // A stretch in the middle runs with neither side idling.
         calm = (items_sent - start >= 150) && (items_sent - start < 250);
         pick = $urandom_range(99);
         if (pick < 80) begin
            size = $urandom_range(1, 12);
         end else if (pick < 94) begin
            size = $urandom_range(13, 40);
         end else begin
            size = $urandom_range(41, gbp_pkg::MAX_VARS + 3);
         end
         for (int i = 0; i < size; i++) begin
            send_range(random_range(), i == size - 1);
         end
      end
      calm = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_stall <= !reset && take_gap();
   end

   always @(posedge clock) begin
      placement_type got;
      placement_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_var_index, rsp_word_index, rsp_bit_offset, rsp_field_width,
                 rsp_final_res};
         if (placements_due.size() == 0) begin
            note_fault($sformatf("placement with none expected: %p", got));
         end else begin
            want = placements_due.pop_front();
            if (got !== want) begin
               note_fault($sformatf("expected %p, got %p", want, got));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("tb_greedy_bitfield_packer: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_single_field();
      test_range_extremes();
      test_zero_width_fields();
      test_whole_word_fields();
      test_oversized_set();
      test_random_sets();
      req_valid = 1'b0;
      while (placements_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && placements_due.size() == 0) begin
         $display("tb_greedy_bitfield_packer: done, clean");
      end else begin
         $display("tb_greedy_bitfield_packer: done, errors");
      end
      $finish;
   end

endmodule
